@@ rtl/efr_pkg.sv @@
// efr_pkg: shared constants, result struct and helpers for the escaped frame receiver.
// No dependencies; compiled first.
package efr_pkg;

    localparam int unsigned MAX_FRAME_DEF = 64;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CRC_W  = 16;

    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1b;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h0d;
    localparam logic [BYTE_W-1:0] BYTE_START = 8'h40;
    localparam logic [BYTE_W-1:0] ESC_MASK   = 8'hff;
    localparam logic [BYTE_W-1:0] RSV_ACK    = 8'h06;
    localparam logic [BYTE_W-1:0] RSV_MSB    = 8'h80;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_ok;
        logic [LEN_W-1:0]  frame_length;
        logic              bad_escape;
        logic              overflow;
    } result_t;

    function automatic logic is_reserved(input logic [BYTE_W-1:0] v);
        return (v == RSV_ACK) || (v == BYTE_END) || (v == BYTE_ESC)
            || (v == BYTE_START) || (v == RSV_MSB);
    endfunction

endpackage

@@ rtl/efr_rx_if.sv @@
// efr_rx_if: valid/ready channel carrying one raw received byte per beat.
// Depends on efr_pkg.
interface efr_rx_if;
    import efr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/efr_res_if.sv @@
// efr_res_if: valid/ready channel carrying one decoded result per beat.
// Depends on efr_pkg.
interface efr_res_if;
    import efr_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_ok;
    logic [LEN_W-1:0]  frame_length;
    logic              bad_escape;
    logic              overflow;

    modport source (output valid, output kind, output data_byte, output frame_ok,
                    output frame_length, output bad_escape, output overflow,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_ok,
                    input frame_length, input bad_escape, input overflow,
                    output ready);
endinterface

@@ rtl/efr_crc_byte.sv @@
// efr_crc_byte: augmented CRC-16 (poly 0x1021), one byte shifted in MSB first.
// Depends on efr_pkg.
module efr_crc_byte (
    input  logic [efr_pkg::CRC_W-1:0]  crc_in,
    input  logic [efr_pkg::BYTE_W-1:0] data_in,
    output logic [efr_pkg::CRC_W-1:0]  crc_out
);
    import efr_pkg::*;

    always_comb
    begin
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1];
            c  = {c[CRC_W-2:0], data_in[i]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

@@ rtl/efr_frame_state.sv @@
// efr_frame_state: per-frame state (CRC, escape, count, flags) and byte decode.
// Depends on efr_pkg and efr_crc_byte.
module efr_frame_state #(
    parameter int unsigned MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [efr_pkg::BYTE_W-1:0] rx_byte,
    output logic                       has_result,
    output efr_pkg::result_t           result
);
    import efr_pkg::*;

    localparam int unsigned LEN_CAP = (MAX_FRAME < 127) ? MAX_FRAME : 127;

    logic [CRC_W-1:0] crc_reg, crc_next, crc_upd;
    logic             esc_reg, esc_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             err_reg, err_next;
    logic             ovf_reg, ovf_next;

    logic [BYTE_W-1:0] val;
    logic              escaped;

    // when an escape is pending the byte is inverted
    assign escaped = esc_reg;
    assign val     = esc_reg ? (rx_byte ^ ESC_MASK) : rx_byte;

    efr_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (val),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        crc_next   = crc_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        has_result = 1'b0;
        result     = '0;

        if (rx_byte == BYTE_START)
        begin
            // start marker dropped, escape stays pending
        end
        else if (rx_byte == BYTE_END)
        begin
            has_result          = 1'b1;
            result.kind         = KIND_END;
            result.frame_ok     = (crc_reg == '0) && (count_reg != '0)
                                  && !ovf_reg && !esc_reg;
            result.frame_length = count_reg;
            result.bad_escape   = err_reg;
            result.overflow     = ovf_reg;
            crc_next   = '0;
            esc_next   = 1'b0;
            count_next = '0;
            err_next   = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (!esc_reg && rx_byte == BYTE_ESC)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            crc_next = crc_upd;
            if (count_reg < LEN_W'(LEN_CAP))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (escaped && !is_reserved(val))
            begin
                err_next          = 1'b1;
                result.bad_escape = 1'b1;
            end
            has_result          = 1'b1;
            result.kind         = KIND_DATA;
            result.data_byte    = val;
            result.frame_length = count_next;
            result.overflow     = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= '0;
            esc_reg   <= 1'b0;
            count_reg <= '0;
            err_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            crc_reg   <= crc_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ rtl/escaped_frame_receiver_crc16_core.sv @@
// escaped_frame_receiver_crc16_core: top level, input register, result register.
// Depends on efr_pkg, efr_rx_if, efr_res_if, efr_frame_state.
//
// Byte-stuffed frame receiver with CRC-16 check. One raw byte is taken per
// beat on rx and the block sustains one byte per clock while res is not
// stalled. A byte is held in an input register, decoded (start marker 0x40
// dropped, escape 0x1b inverts the next byte, 0x0d closes the frame) and
// its result is registered in the result register, which drives res.valid.
// Data bytes come out as kind 0 with the running length; the frame end
// comes out as kind 1 with the length and frame_ok, which needs a zero
// CRC register, a nonzero length, no overflow and no dangling escape. The
// rate is set by the combinational byte CRC update and frame-state loop in
// efr_frame_state. The start marker and escape bytes yield no result and
// never wait on res. The length saturates at MAX_FRAME (capped at 127). No
// clearing pass is needed after reset.
module escaped_frame_receiver_crc16_core #(
    parameter int unsigned MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    efr_rx_if.sink    rx,
    efr_res_if.source res
);
    import efr_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    has_result;
    result_t result;
    logic    out_free;
    logic    advance;

    efr_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    // result slot free when empty or being drained this cycle
    assign out_free = !out_valid_reg || res.ready;
    // bytes with no result move on regardless of the output side
    assign advance  = in_valid_reg && (!has_result || out_free);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (out_free && advance && has_result)
        begin
            out_data_reg <= result;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_data_reg.kind;
    assign res.data_byte    = out_data_reg.data_byte;
    assign res.frame_ok     = out_data_reg.frame_ok;
    assign res.frame_length = out_data_reg.frame_length;
    assign res.bad_escape   = out_data_reg.bad_escape;
    assign res.overflow     = out_data_reg.overflow;

endmodule
